/* rtl/btic_pkg.sv */
// Shared constants and types for the binary trie insert block.
package btic_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned NODES_OUT_W = 13;

  localparam logic [LEVEL_W-1:0] TOP_BIT_RESET = LEVEL_W'(31);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [COUNT_W-1:0]     leaf_count;
    logic [NODES_OUT_W-1:0] nodes_used;
    logic                   pool_full;
  } btic_result_t;

endpackage

/* rtl/btic_if.sv */
// Channel interfaces: key items in, result items out, top_bit register writes.
interface btic_key_if import btic_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, output key_value, input ready);
  modport sink   (input valid, input key_value, output ready);
endinterface

interface btic_res_if import btic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_W-1:0]     leaf_count;
  logic [NODES_OUT_W-1:0] nodes_used;
  logic                   pool_full;

  modport source (output valid, output leaf_count, output nodes_used, output pool_full,
                  input ready);
  modport sink   (input valid, input leaf_count, input nodes_used, input pool_full,
                  output ready);
endinterface

interface btic_cfg_if import btic_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] top_bit;

  modport source (output valid, output top_bit, input ready);
  modport sink   (input valid, input top_bit, output ready);
endinterface

/* rtl/btic_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
module btic_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/btic_walk.sv */
// Trie walk sequencer: one read-modify-write of the node memories per level.
module btic_walk import btic_pkg::*; #(
  parameter int unsigned POOL_NODES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [KEY_W-1:0]                start_key,
  input  logic [LEVEL_W-1:0]              top_bit,
  output logic                            idle,
  input  logic [COUNT_W-1:0]              cnt_rdata,
  input  logic [2*$clog2(POOL_NODES)-1:0] link_rdata,
  output logic [$clog2(POOL_NODES)-1:0]   rd_addr,
  output logic                            wr_en,
  output logic [$clog2(POOL_NODES)-1:0]   wr_addr,
  output logic [COUNT_W-1:0]              cnt_wdata,
  output logic [2*$clog2(POOL_NODES)-1:0] link_wdata,
  output logic                            res_valid,
  input  logic                            res_take,
  output btic_result_t                    res
);

  localparam int unsigned NODE_W = $clog2(POOL_NODES);
  localparam int unsigned FREE_W = $clog2(POOL_NODES + 1);
  localparam logic [FREE_W-1:0] POOL_END = FREE_W'(POOL_NODES);

  typedef enum logic [1:0] {IDLE, WALK, HOLD} state_t;

  state_t              state;
  logic [KEY_W-1:0]    key;
  logic [LEVEL_W-1:0]  level;
  logic                at_leaf;
  logic [NODE_W-1:0]   node;
  logic                fresh;
  logic                root_init;
  logic [FREE_W-1:0]   next_free;

  logic [COUNT_W-1:0]  cur_cnt;
  logic [2*NODE_W-1:0] cur_links;
  logic [COUNT_W-1:0]  bumped;
  logic                branch;
  logic [NODE_W-1:0]   child;
  logic                missing;
  logic                pool_out;
  logic                alloc;
  logic                stop_full;
  logic [NODE_W-1:0]   next_node;
  logic [2*NODE_W-1:0] new_links;

  // modify the node just read; a freshly taken node reads as empty
  always_comb begin
    cur_cnt   = fresh ? '0 : cnt_rdata;
    cur_links = fresh ? '0 : link_rdata;
    bumped    = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1);
    branch    = key[level];
    child     = branch ? cur_links[2*NODE_W-1:NODE_W] : cur_links[NODE_W-1:0];
    missing   = (child == '0);
    pool_out  = (next_free == POOL_END);
    alloc     = !at_leaf && missing && !pool_out;
    stop_full = !at_leaf && missing && pool_out;
    next_node = alloc ? next_free[NODE_W-1:0] : child;
    new_links = cur_links;
    if (alloc) begin
      if (branch) begin
        new_links[2*NODE_W-1:NODE_W] = next_free[NODE_W-1:0];
      end else begin
        new_links[NODE_W-1:0] = next_free[NODE_W-1:0];
      end
    end
  end

  // memory ports: root is read while waiting, the next node while walking
  assign rd_addr    = (state == WALK) ? next_node : '0;
  assign wr_en      = (state == WALK);
  assign wr_addr    = node;
  assign cnt_wdata  = bumped;
  assign link_wdata = new_links;

  assign idle      = (state == IDLE);
  assign res_valid = (state == HOLD);

  // sequencer and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      root_init <= 1'b0;
      next_free <= FREE_W'(1);
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            key     <= start_key;
            level   <= top_bit;
            at_leaf <= 1'b0;
            node    <= '0;
            fresh   <= !root_init;
            state   <= WALK;
          end
        end
        WALK: begin
          if (node == '0) begin
            root_init <= 1'b1;
          end
          if (alloc) begin
            next_free <= next_free + FREE_W'(1);
          end
          if (at_leaf) begin
            res.leaf_count <= bumped;
            res.nodes_used <= NODES_OUT_W'(next_free);
            res.pool_full  <= 1'b0;
            state          <= HOLD;
          end else if (stop_full) begin
            res.leaf_count <= '0;
            res.nodes_used <= NODES_OUT_W'(next_free);
            res.pool_full  <= 1'b1;
            state          <= HOLD;
          end else begin
            node  <= next_node;
            fresh <= alloc;
            if (level == '0) begin
              at_leaf <= 1'b1;
            end else begin
              level <= level - LEVEL_W'(1);
            end
          end
        end
        HOLD: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/binary_trie_insert_counts.sv */
// Binary trie insert with saturating pass counts: top level.
// A key is taken only while the walker is idle, so the next key waits until the result
// has moved to the output register; each key costs one node memory read-modify-write
// per trie level walked plus the leaf update.
// Reset empties the trie at once: the allocation count returns to one and
// the root reads as empty until first written; top_bit returns to 31.
module binary_trie_insert_counts import btic_pkg::*; #(
  parameter int unsigned POOL_NODES = 4096
) (
  input  logic       clk,
  input  logic       rst,
  btic_cfg_if.sink   cfg,
  btic_key_if.sink   keys,
  btic_res_if.source results
);

  localparam int unsigned NODE_W = $clog2(POOL_NODES);

  logic [LEVEL_W-1:0]  top_bit;
  logic                walk_idle;
  logic                start;
  logic [COUNT_W-1:0]  cnt_rdata;
  logic [2*NODE_W-1:0] link_rdata;
  logic [NODE_W-1:0]   rd_addr;
  logic                wr_en;
  logic [NODE_W-1:0]   wr_addr;
  logic [COUNT_W-1:0]  cnt_wdata;
  logic [2*NODE_W-1:0] link_wdata;
  logic                res_valid;
  logic                res_take;
  btic_result_t        res;

  // configuration register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_bit <= TOP_BIT_RESET;
    end else if (cfg.valid) begin
      top_bit <= cfg.top_bit;
    end
  end

  // take a key only when the walker is free
  assign keys.ready = walk_idle;
  assign start      = keys.valid && walk_idle;

  btic_ram #(.DEPTH(POOL_NODES), .WIDTH(COUNT_W)) u_count_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  btic_ram #(.DEPTH(POOL_NODES), .WIDTH(2*NODE_W)) u_link_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  btic_walk #(.POOL_NODES(POOL_NODES)) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_key  (keys.key_value),
    .top_bit    (top_bit),
    .idle       (walk_idle),
    .cnt_rdata  (cnt_rdata),
    .link_rdata (link_rdata),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .cnt_wdata  (cnt_wdata),
    .link_wdata (link_wdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // output register: load when empty or being drained
  assign res_take = res_valid && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (res_take) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      results.leaf_count <= res.leaf_count;
      results.nodes_used <= res.nodes_used;
      results.pool_full  <= res.pool_full;
    end
  end

endmodule

/* tb/tb_binary_trie_insert_counts.sv */
// Testbench for binary_trie_insert_counts: directed and random key inserts checked against a trie shadow.
`timescale 1ns / 1ps
module tb_binary_trie_insert_counts;
  import btic_pkg::*;

  localparam int unsigned POOL_NODES  = 4096;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HISTORY_LEN = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;

  btic_cfg_if cfg_if ();
  btic_key_if keys_if ();
  btic_res_if res_if ();

  binary_trie_insert_counts #(.POOL_NODES(POOL_NODES)) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .keys    (keys_if),
    .results (res_if)
  );

  // Shadow trie: child links, pass counts, allocation pointer and depth register
  int unsigned        child_link [POOL_NODES][2];
  bit [COUNT_W-1:0]   pass_count [POOL_NODES];
  int unsigned        nodes_alloc  = 1;
  logic [LEVEL_W-1:0] trie_top_bit = TOP_BIT_RESET;

  logic [KEY_W-1:0] pending_keys [$];
  logic [KEY_W-1:0] key_history [$];
  btic_result_t     due_outcomes [$];
  btic_result_t     want_outcome;

  bit                 idle_on = 1'b1;
  int unsigned        key_gap;
  int unsigned        res_stall;
  int unsigned        keys_accepted = 0;
  int unsigned        results_seen  = 0;
  int unsigned        full_seen     = 0;
  int unsigned        error_count   = 0;
  logic [COUNT_W-1:0] top_leaf      = '0;

  // Invert the clock every half period
  always #6 clk = ~clk;

  // Walk the shadow trie for one key and return the outcome the block must report
  function automatic btic_result_t insert_key(input logic [KEY_W-1:0] key);
    int unsigned  node;
    int unsigned  nxt;
    int           lvl;
    bit           full;
    btic_result_t outcome;
    node = 0;
    full = 1'b0;
    for (lvl = int'(trie_top_bit); lvl >= 0; lvl--) begin
      if (pass_count[node] != COUNT_MAX) pass_count[node]++;
      nxt = child_link[node][key[lvl]];
      if (nxt == 0) begin
        // No free node left: stop, leaving counts raised so far
        if (nodes_alloc >= POOL_NODES) begin
          full = 1'b1;
          break;
        end
        nxt = nodes_alloc;
        nodes_alloc++;
        child_link[node][key[lvl]] = nxt;
      end
      node = nxt;
    end
    if (!full && pass_count[node] != COUNT_MAX) pass_count[node]++;
    outcome.leaf_count = full ? '0 : pass_count[node];
    outcome.nodes_used = NODES_OUT_W'(nodes_alloc);
    outcome.pool_full  = full;
    return outcome;
  endfunction

  // Key driver: predict on each accepted item, then offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      keys_if.valid <= 1'b0;
      key_gap       <= 0;
    end else begin
      if (keys_if.valid && keys_if.ready) begin
        keys_accepted++;
        due_outcomes = {due_outcomes, insert_key(keys_if.key_value)};
      end
      if (!keys_if.valid || keys_if.ready) begin
        if (key_gap != 0) begin
          key_gap       <= key_gap - 1;
          keys_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          key_gap       <= $urandom_range(0, 5);
          keys_if.valid <= 1'b0;
        end else if (pending_keys.size() != 0) begin
          keys_if.valid     <= 1'b1;
          keys_if.key_value <= pending_keys.pop_front();
        end else begin
          keys_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted item with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      res_stall    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (res_if.pool_full) full_seen++;
        if (due_outcomes.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result: leaf %0d nodes %0d full %0b", $realtime,
                     res_if.leaf_count, res_if.nodes_used, res_if.pool_full);
        end else begin
          want_outcome = due_outcomes.pop_front();
          if (want_outcome.leaf_count > top_leaf) top_leaf = want_outcome.leaf_count;
          if (res_if.leaf_count !== want_outcome.leaf_count ||
              res_if.nodes_used !== want_outcome.nodes_used ||
              res_if.pool_full  !== want_outcome.pool_full) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected leaf %0d nodes %0d full %0b, got %0d %0d %0b",
                       $realtime, want_outcome.leaf_count, want_outcome.nodes_used,
                       want_outcome.pool_full, res_if.leaf_count, res_if.nodes_used,
                       res_if.pool_full);
          end
        end
      end
      // Stall the result channel in short bursts
      if (res_stall != 0) begin
        res_stall    <= res_stall - 1;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        res_stall    <= $urandom_range(0, 5);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Hold until every key is in and every result is out, then let the walk settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_keys.size() != 0 || keys_if.valid || due_outcomes.size() != 0);
    repeat (int'(trie_top_bit) + 6) @(negedge clk);
  endtask

  // Write the depth register once the block is idle
  task automatic write_top_bit(input logic [LEVEL_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.top_bit <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    trie_top_bit = value;
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Queue random keys: fresh values, repeats of earlier keys, and near neighbours
  task automatic queue_random_keys(input int unsigned count);
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (key_history.size() == 0 || pick < 35)
        key = $urandom();
      else if (pick < 75)
        key = key_history[$urandom_range(0, key_history.size() - 1)];
      else
        key = key_history[$urandom_range(0, key_history.size() - 1)] ^
              (KEY_W'(1) << $urandom_range(0, int'(trie_top_bit)));
      pending_keys = {pending_keys, key};
      if (key_history.size() == HISTORY_LEN) void'(key_history.pop_front());
      key_history = {key_history, key};
    end
  endtask

  initial begin
    int unsigned phase_top   [8] = '{5, 31, 12, 31, 20, 0, 9, 31};
    int unsigned phase_items [8] = '{180, 300, 200, 300, 250, 120, 200, 250};
    bit          phase_idle  [8] = '{1, 1, 1, 0, 1, 1, 1, 0};
    cfg_if.valid      = 1'b0;
    cfg_if.top_bit    = '0;
    keys_if.valid     = 1'b0;
    keys_if.key_value = '0;
    res_if.ready      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Full depth after reset: extremes, a repeat and alternating patterns
    pending_keys = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                    32'h0000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    // Shallowest depth: only bit zero chooses the branch
    write_top_bit(LEVEL_W'(0));
    pending_keys = {32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    write_top_bit(LEVEL_W'(1));
    pending_keys = {32'h0000_0002, 32'hFFFF_FFFF};

    // Random phases at several depths; the pool runs out along the way
    for (int p = 0; p < 8; p++) begin
      write_top_bit(LEVEL_W'(phase_top[p]));
      idle_on = phase_idle[p];
      queue_random_keys(phase_items[p]);
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Inserted %0d keys at depths 0 to 31: %0d results, %0d on a full pool, %0d mismatches.",
             keys_accepted, results_seen, full_seen, error_count);
    $display("Trie ended with %0d of %0d nodes in use; largest leaf count %0d.",
             nodes_alloc, POOL_NODES, top_leaf);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Abandon a run that never drains
  initial begin
    #20000000;
    $display("Timeout: results did not drain");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/btic_pkg.sv
rtl/btic_if.sv
rtl/btic_ram.sv
rtl/btic_walk.sv
rtl/binary_trie_insert_counts.sv
tb/tb_binary_trie_insert_counts.sv
